// ===== hdl/tspr_pkg.sv =====
// Shared types, constants and helper functions for the tile and sprite pixel renderer.
package tspr_pkg;

    localparam int VRAM_DEPTH      = 8192;
    localparam int VRAM_AW         = 13;
    localparam int OAM_DEPTH       = 160;
    localparam int OAM_AW          = 8;
    localparam int DEF_SCREEN_WIDTH = 160;
    localparam int DEF_SPRITE_COUNT = 40;
    localparam int CFG_COUNT       = 8;
    localparam int CFG_AW          = 3;

    localparam logic [1:0] CMD_VRAM   = 2'd0;
    localparam logic [1:0] CMD_OAM    = 2'd1;
    localparam logic [1:0] CMD_RENDER = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] REG_LCDC = 3'd0;
    localparam logic [2:0] REG_SCX  = 3'd1;
    localparam logic [2:0] REG_SCY  = 3'd2;
    localparam logic [2:0] REG_WX   = 3'd3;
    localparam logic [2:0] REG_WY   = 3'd4;
    localparam logic [2:0] REG_BGP  = 3'd5;
    localparam logic [2:0] REG_OBP0 = 3'd6;
    localparam logic [2:0] REG_OBP1 = 3'd7;

    localparam logic [7:0] LCDC_RESET = 8'h91;
    localparam logic [7:0] BGP_RESET  = 8'hFC;
    localparam logic [12:0] MAP_LO    = 13'h1800;
    localparam logic [12:0] MAP_HI    = 13'h1C00;
    localparam logic [12:0] TILE_SIGNED_BASE = 13'h0800;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [12:0] mem_addr;
        logic [7:0]  mem_data;
        logic [7:0]  pixel_x;
        logic [7:0]  line_y;
    } in_word_t;

    typedef struct packed {
        logic [1:0] shade;
        logic       drawn;
    } out_word_t;

    typedef struct packed {
        logic [7:0] lcdc;
        logic [7:0] scx;
        logic [7:0] scy;
        logic [7:0] wx;
        logic [7:0] wy;
        logic [7:0] bgp;
        logic [7:0] obp0;
        logic [7:0] obp1;
    } cfg_t;

    function automatic logic [1:0] plane_color(input logic [7:0] lo, input logic [7:0] hi,
                                               input logic [2:0] col);
        logic [2:0] b;
        b = 3'd7 - col;
        return {hi[b], lo[b]};
    endfunction

    function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] c);
        return pal[{c, 1'b0} +: 2];
    endfunction

endpackage

// ===== hdl/tspr_ram.sv =====
// Generic single-port-write, single-read RAM with a registered read.
module tspr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/tile_sprite_pixel_renderer.sv =====
// Top level of the tile and sprite pixel renderer: control sequencer and memories.
// A memory write word is done in the map state. A render word with an on-screen column reads the
// background or window tile bytes when that layer is on, then each sprite slot's table entry and
// tile bytes with sprites on, as the sprite table and video RAM are read one byte per cycle.
// A waiting result holds the sequencer until it is taken, so throughput is one word at a time.
// After reset a clearing pass writes zero to all 8192 video RAM bytes, one per cycle,
// during which no input word is accepted; configuration writes are taken throughout.
// Reset is asynchronous and active low; registers return to their documented values.
module tile_sprite_pixel_renderer
    import tspr_pkg::*;
#(
    parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH,
    parameter int SPRITE_COUNT = DEF_SPRITE_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_data,
    input  logic        cfg_we,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int SW = SCREEN_WIDTH;
    localparam int NS = SPRITE_COUNT;
    localparam int SIW = (NS > 1) ? $clog2(NS) : 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MAP   = 4'd2;
    localparam logic [3:0] S_MAPW  = 4'd3;
    localparam logic [3:0] S_BLO   = 4'd4;
    localparam logic [3:0] S_BHI   = 4'd5;
    localparam logic [3:0] S_BFIN  = 4'd6;
    localparam logic [3:0] S_OY    = 4'd7;
    localparam logic [3:0] S_OX    = 4'd8;
    localparam logic [3:0] S_OT    = 4'd9;
    localparam logic [3:0] S_OF    = 4'd10;
    localparam logic [3:0] S_SLO   = 4'd11;
    localparam logic [3:0] S_SHI   = 4'd12;
    localparam logic [3:0] S_SFIN  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    cfg_t cfg_reg;
    logic [3:0] state_reg, state_next;
    logic [VRAM_AW-1:0] clr_reg;
    in_word_t item_reg;
    logic [7:0] ox_reg, oy_reg, sy_reg, sx_reg, tile_reg, lo_reg;
    logic [12:0] map_reg;
    logic pal1_reg, hit_reg;
    logic [SIW-1:0] spr_reg;
    logic [1:0] shade_reg;
    logic drawn_reg;
    logic out_valid_reg;
    out_word_t out_reg;

    logic vwe, owe;
    logic [VRAM_AW-1:0] vwaddr, vraddr;
    logic [7:0] vwdata, vrdata, ordata;
    logic [OAM_AW-1:0] oraddr;

    tspr_ram #(.WIDTH(8), .DEPTH(VRAM_DEPTH), .AW(VRAM_AW)) u_vram (
        .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
        .raddr(vraddr), .rdata(vrdata));

    tspr_ram #(.WIDTH(8), .DEPTH(OAM_DEPTH), .AW(OAM_AW)) u_oam (
        .clk(clk), .we(owe), .waddr(item_reg.mem_addr[OAM_AW-1:0]),
        .wdata(item_reg.mem_data), .raddr(oraddr), .rdata(ordata));

    wire accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{LCDC_RESET, 8'd0, 8'd0, 8'd0, 8'd0, BGP_RESET, 8'd0, 8'd0};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LCDC: cfg_reg.lcdc <= cfg_data;
                REG_SCX:  cfg_reg.scx  <= cfg_data;
                REG_SCY:  cfg_reg.scy  <= cfg_data;
                REG_WX:   cfg_reg.wx   <= cfg_data;
                REG_WY:   cfg_reg.wy   <= cfg_data;
                REG_BGP:  cfg_reg.bgp  <= cfg_data;
                REG_OBP0: cfg_reg.obp0 <= cfg_data;
                REG_OBP1: cfg_reg.obp1 <= cfg_data;
                default:  cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Layer selection for the background fetch.
    logic win_on, bg_on;
    logic [8:0] px7;
    assign px7 = {1'b0, item_reg.pixel_x} + 9'd7;
    assign bg_on = cfg_reg.lcdc[0];
    assign win_on = cfg_reg.lcdc[5] && (cfg_reg.wy <= item_reg.line_y)
                    && (px7 >= {1'b0, cfg_reg.wx});

    logic [7:0] ox_calc, oy_calc;
    logic [12:0] map_calc;

    always_comb
    begin
        if (win_on)
        begin
            ox_calc = 8'(px7 - {1'b0, cfg_reg.wx});
            oy_calc = item_reg.line_y - cfg_reg.wy;
            map_calc = cfg_reg.lcdc[6] ? MAP_HI : MAP_LO;
        end
        else
        begin
            ox_calc = cfg_reg.scx + item_reg.pixel_x;
            oy_calc = cfg_reg.scy + item_reg.line_y;
            map_calc = cfg_reg.lcdc[3] ? MAP_HI : MAP_LO;
        end
    end

    logic [7:0] tile_id;
    logic [12:0] tile_base;
    assign tile_id = vrdata;
    assign tile_base = cfg_reg.lcdc[4] ? {1'b0, tile_id, 4'd0}
                       : TILE_SIGNED_BASE + {1'b0, tile_id ^ 8'h80, 4'd0};

    logic [8:0] sy_sum;
    logic [7:0] sh;
    logic [7:0] dy;
    logic [7:0] spr_tile;
    logic [12:0] spr_addr;
    logic [1:0] spr_col;
    assign sh = cfg_reg.lcdc[2] ? 8'd16 : 8'd8;
    assign sy_sum = {1'b0, sy_reg} + {1'b0, sh};
    assign dy = item_reg.line_y - sy_reg;
    assign spr_tile = cfg_reg.lcdc[2] ? {tile_reg[7:1], 1'b0} : tile_reg;
    assign spr_addr = {1'b0, spr_tile, 4'd0} + {4'd0, dy, 1'b0};
    assign spr_col = plane_color(lo_reg, vrdata, 3'(item_reg.pixel_x - sx_reg));

    logic [8:0] sx_end;
    assign sx_end = {1'b0, sx_reg} + 9'd8;

    logic spr_hit;
    assign spr_hit = (item_reg.line_y >= sy_reg) && ({1'b0, item_reg.line_y} < sy_sum)
                     && (item_reg.pixel_x >= sx_reg)
                     && ({1'b0, item_reg.pixel_x} < sx_end);

    logic [OAM_AW-1:0] spr_base;
    assign spr_base = OAM_AW'({spr_reg, 2'b00});

    always_comb
    begin
        state_next = state_reg;
        vwe = 1'b0;
        vwaddr = item_reg.mem_addr;
        vwdata = item_reg.mem_data;
        owe = 1'b0;
        vraddr = '0;
        oraddr = spr_base;
        case (state_reg)
            S_CLEAR:
            begin
                vwe = 1'b1;
                vwaddr = clr_reg;
                vwdata = 8'd0;
                if (clr_reg == VRAM_AW'(VRAM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                vraddr = map_calc + {3'd0, oy_calc[7:3], ox_calc[7:3]};
                if (item_reg.cmd == CMD_VRAM)
                begin
                    vwe = 1'b1;
                    state_next = S_IDLE;
                end
                else if (item_reg.cmd == CMD_OAM)
                begin
                    owe = (item_reg.mem_addr < 13'(OAM_DEPTH));
                    state_next = S_IDLE;
                end
                else if (item_reg.cmd != CMD_RENDER)
                begin
                    state_next = S_IDLE;
                end
                else if (32'(item_reg.pixel_x) >= SW)
                begin
                    state_next = S_OUT;
                end
                else if (bg_on || win_on)
                begin
                    state_next = S_MAPW;
                end
                else
                begin
                    state_next = cfg_reg.lcdc[1] ? S_OY : S_OUT;
                end
            end
            S_MAPW:
            begin
                vraddr = tile_base + {4'd0, oy_reg[2:0], 1'b0};
                state_next = S_BLO;
            end
            S_BLO:
            begin
                vraddr = map_reg;
                state_next = S_BHI;
            end
            S_BHI:
            begin
                vraddr = map_reg;
                state_next = S_BFIN;
            end
            S_BFIN:
            begin
                state_next = cfg_reg.lcdc[1] ? S_OY : S_OUT;
            end
            S_OY:
            begin
                oraddr = spr_base;
                state_next = S_OX;
            end
            S_OX:
            begin
                oraddr = spr_base + OAM_AW'(1);
                state_next = S_OT;
            end
            S_OT:
            begin
                oraddr = spr_base + OAM_AW'(2);
                state_next = S_OF;
            end
            S_OF:
            begin
                oraddr = spr_base + OAM_AW'(3);
                state_next = S_SLO;
            end
            S_SLO:
            begin
                vraddr = spr_addr;
                state_next = S_SHI;
            end
            S_SHI:
            begin
                vraddr = spr_addr + 13'd1;
                state_next = S_SFIN;
            end
            S_SFIN:
            begin
                state_next = (spr_reg == SIW'(NS - 1)) ? S_OUT : S_OY;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            spr_reg <= '0;
            drawn_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + VRAM_AW'(1);
            end
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_IDLE)
            begin
                drawn_reg <= 1'b0;
                spr_reg <= '0;
            end
            if (state_reg == S_BFIN)
            begin
                drawn_reg <= 1'b1;
            end
            if (state_reg == S_SFIN)
            begin
                if (hit_reg && spr_col != 2'd0)
                begin
                    drawn_reg <= 1'b1;
                end
                spr_reg <= spr_reg + SIW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept)
        begin
            item_reg <= in_data;
        end
        case (state_reg)
            S_IDLE:
            begin
                shade_reg <= 2'd0;
            end
            S_MAP:
            begin
                ox_reg <= ox_calc;
                oy_reg <= oy_calc;
                map_reg <= map_calc;
            end
            S_MAPW:
            begin
                map_reg <= tile_base + {4'd0, oy_reg[2:0], 1'b0} + 13'd1;
            end
            S_BLO:
            begin
                lo_reg <= vrdata;
            end
            S_BFIN:
            begin
                shade_reg <= pal_shade(cfg_reg.bgp, plane_color(lo_reg, vrdata, ox_reg[2:0]));
            end
            S_OX:   sy_reg <= ordata - 8'd16;
            S_OT:   sx_reg <= ordata - 8'd8;
            S_OF:   tile_reg <= ordata;
            S_SLO:
            begin
                pal1_reg <= ordata[4];
                hit_reg <= spr_hit;
            end
            S_SFIN:
            begin
                if (hit_reg && spr_col != 2'd0)
                begin
                    shade_reg <= pal_shade(pal1_reg ? cfg_reg.obp1 : cfg_reg.obp0, spr_col);
                end
            end
            default: shade_reg <= shade_reg;
        endcase
        if (state_reg == S_SHI)
        begin
            lo_reg <= vrdata;
        end
        if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
        begin
            out_reg.drawn <= drawn_reg;
            out_reg.shade <= drawn_reg ? shade_reg : 2'd0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("word accepted during clearing pass");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(out_data))
        else $error("result lost under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.drawn) |-> (out_data.shade == 2'd0))
        else $error("undrawn pixel with a shade");

endmodule

// ===== test/tb_tile_sprite_pixel_renderer.sv =====
// Testbench for the tile and sprite pixel renderer: random words checked against a pixel predictor.
module tb_tile_sprite_pixel_renderer;
    import tspr_pkg::*;

    class pixel_scoreboard;
        logic [7:0] vram [VRAM_DEPTH];
        logic [7:0] sprites [OAM_DEPTH];
        logic [7:0] regs [CFG_COUNT];
        out_word_t  pending_pixels [$];
        int         mismatches;
        int         pixels_checked;

        function void clear();
            foreach (vram[i]) vram[i] = 8'h00;
            foreach (sprites[i]) sprites[i] = 8'h00;
            foreach (regs[i]) regs[i] = 8'h00;
            regs[REG_LCDC] = LCDC_RESET;
            regs[REG_BGP] = BGP_RESET;
            mismatches = 0;
            pixels_checked = 0;
        endfunction

        function logic [1:0] tile_color(logic [7:0] lo, logic [7:0] hi, int col);
            int b;
            b = 7 - (col & 7);
            return {hi[b], lo[b]};
        endfunction

        function logic [1:0] palette_shade(logic [7:0] pal, logic [1:0] c);
            return pal[2 * c +: 2];
        endfunction

        function void note_word(in_word_t w);
            logic [7:0] lcdc;
            int px, ly, ox, oy, map, id, base, a, h, sy, sx, tile;
            bit layer;
            out_word_t r;
            logic [1:0] c;
            lcdc = regs[REG_LCDC];
            r = '0;
            if (w.cmd == CMD_VRAM)
                vram[w.mem_addr] = w.mem_data;
            else if (w.cmd == CMD_OAM) begin
                if (w.mem_addr < OAM_DEPTH)
                    sprites[w.mem_addr] = w.mem_data;
            end
            else if (w.cmd == CMD_RENDER) begin
                px = w.pixel_x;
                ly = w.line_y;
                if (px < DEF_SCREEN_WIDTH) begin
                    layer = 0;
                    if (lcdc[0]) begin
                        ox = (regs[REG_SCX] + px) & 255;
                        oy = (regs[REG_SCY] + ly) & 255;
                        map = lcdc[3] ? MAP_HI : MAP_LO;
                        layer = 1;
                    end
                    if (lcdc[5] && regs[REG_WY] <= ly && px + 7 >= regs[REG_WX]) begin
                        ox = (px + 7 - regs[REG_WX]) & 255;
                        oy = (ly - regs[REG_WY]) & 255;
                        map = lcdc[6] ? MAP_HI : MAP_LO;
                        layer = 1;
                    end
                    if (layer) begin
                        id = vram[(map + (oy >> 3) * 32 + (ox >> 3)) & 8191];
                        base = lcdc[4] ? id * 16 : TILE_SIGNED_BASE + (id ^ 8'h80) * 16;
                        a = base + (oy & 7) * 2;
                        r.shade = palette_shade(regs[REG_BGP],
                                                tile_color(vram[a & 8191], vram[(a + 1) & 8191], ox));
                        r.drawn = 1'b1;
                    end
                    if (lcdc[1]) begin
                        h = lcdc[2] ? 16 : 8;
                        for (int s = 0; s < DEF_SPRITE_COUNT; s++) begin
                            sy = (sprites[4 * s] - 16) & 255;
                            sx = (sprites[4 * s + 1] - 8) & 255;
                            if (ly >= sy && ly < sy + h && px >= sx && px < sx + 8) begin
                                tile = sprites[4 * s + 2];
                                if (h == 16)
                                    tile = tile & 8'hFE;
                                a = tile * 16 + (ly - sy) * 2;
                                c = tile_color(vram[a & 8191], vram[(a + 1) & 8191], px - sx);
                                if (c != 2'd0) begin
                                    r.shade = palette_shade(sprites[4 * s + 3][4] ?
                                                            regs[REG_OBP1] : regs[REG_OBP0], c);
                                    r.drawn = 1'b1;
                                end
                            end
                        end
                    end
                end
                pending_pixels.push_back(r);
            end
        endfunction

        function void check_word(out_word_t got);
            out_word_t exp_w;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected pixel word: shade %0d drawn %0d", got.shade, got.drawn);
                return;
            end
            exp_w = pending_pixels.pop_front();
            pixels_checked++;
            if (got.shade !== exp_w.shade || got.drawn !== exp_w.drawn) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Pixel %0d mismatch: expected shade %0d drawn %0d, got shade %0d drawn %0d",
                             pixels_checked, exp_w.shade, exp_w.drawn, got.shade, got.drawn);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 3000000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_data;
    logic      cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    pixel_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int cycles = 0;
    int words_sent = 0;
    int settings_used = 0;

    tile_sprite_pixel_renderer u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(out_data);
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic write_regs(logic [7:0] vals [CFG_COUNT]);
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i[CFG_AW-1:0];
            cfg_data <= vals[i];
            sb.regs[i] = vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic in_word_t make_word(logic [1:0] cmd, int addr, int data, int px, int ly);
        in_word_t w;
        w.cmd = cmd;
        w.mem_addr = addr[12:0];
        w.mem_data = data[7:0];
        w.pixel_x = px[7:0];
        w.line_y = ly[7:0];
        return w;
    endfunction

    function automatic int sprite_byte(int idx);
        case (idx % 4)
            0: return $urandom_range(175, 16);
            1: return $urandom_range(167, 8);
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic in_word_t random_word();
        int pick, addr, px, ly;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            case ($urandom_range(4))
                0, 1: addr = $urandom_range(13'h1FFF, MAP_LO);
                2, 3: addr = $urandom_range(MAP_LO - 1);
                default: addr = $urandom_range(8191);
            endcase
            return make_word(CMD_VRAM, addr, $urandom_range(255), $urandom_range(255),
                             $urandom_range(255));
        end
        if (pick < 40)
        begin
            addr = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(159);
            return make_word(CMD_OAM, addr, sprite_byte(addr), $urandom_range(255),
                             $urandom_range(255));
        end
        if (pick < 44)
            return make_word(CMD_UNUSED, $urandom_range(8191), $urandom_range(255),
                             $urandom_range(255), $urandom_range(255));
        px = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(159);
        ly = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(143);
        return make_word(CMD_RENDER, $urandom_range(8191), $urandom_range(255), px, ly);
    endfunction

    initial
    begin
        logic [7:0] vals [CFG_COUNT];
        sb.clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // The sprite table is filled first, since every render with sprites on reads all of it.
        for (int i = 0; i < OAM_DEPTH; i++)
            send_word(make_word(CMD_OAM, i, sprite_byte(i), 0, 0));

        send_word(make_word(CMD_VRAM, 0, 8'hFF, 0, 0));
        send_word(make_word(CMD_VRAM, 1, 8'h0F, 0, 0));
        send_word(make_word(CMD_VRAM, 8191, 8'hFF, 255, 255));
        send_word(make_word(CMD_VRAM, MAP_LO, 8'h00, 0, 0));
        send_word(make_word(CMD_VRAM, MAP_HI + 33, 8'h80, 0, 0));
        send_word(make_word(CMD_OAM, 160, 8'hAA, 0, 0));
        send_word(make_word(CMD_OAM, 8191, 8'h55, 0, 0));
        send_word(make_word(CMD_UNUSED, 8191, 8'hFF, 255, 255));
        send_word(make_word(CMD_RENDER, 0, 0, 0, 0));
        send_word(make_word(CMD_RENDER, 0, 0, 159, 143));
        send_word(make_word(CMD_RENDER, 0, 0, 160, 0));
        send_word(make_word(CMD_RENDER, 0, 0, 255, 255));

        // Window with a left edge below seven, signed tile ids and tall sprites.
        vals = '{8'hE7, 8'd255, 8'd255, 8'd3, 8'd0, 8'h1B, 8'hE4, 8'h27};
        write_regs(vals);
        send_word(make_word(CMD_RENDER, 0, 0, 0, 0));
        send_word(make_word(CMD_RENDER, 0, 0, 8, 8));
        send_word(make_word(CMD_RENDER, 0, 0, 159, 143));
        send_word(make_word(CMD_RENDER, 0, 0, 200, 10));
        for (int i = 0; i < 6; i++)
            send_word(make_word(CMD_RENDER, 0, 0, $urandom_range(159), $urandom_range(143)));

        for (int ph = 0; ph < 12; ph++)
        begin
            send_idle = (ph < 4) ? 20 : (ph < 8) ? 48 : 0;
            recv_idle = (ph < 4) ? 48 : (ph < 8) ? 20 : 0;
            foreach (vals[i])
                vals[i] = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom_range(255));
            if (ph > 1 && $urandom_range(1))
                vals[REG_WX] = 8'($urandom_range(166));
            write_regs(vals);
            for (int n = 0; n < 147; n++)
                send_word(random_word());
        end
        in_valid <= 1'b0;

        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Checked %0d pixel results from %0d accepted words.",
                 sb.pixels_checked, words_sent);
        $display("Used %0d register settings; %0d mismatches.", settings_used, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/tspr_pkg.sv
hdl/tspr_ram.sv
hdl/tile_sprite_pixel_renderer.sv
test/tb_tile_sprite_pixel_renderer.sv
